FILE: rtl/core/stack_map_table_parser_assert.svh
// assertion macros for the stack map table parser checker
`ifndef STACK_MAP_TABLE_PARSER_ASSERT_SVH
`define STACK_MAP_TABLE_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMTP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smtp check failed");

// next-cycle implication, sampled on clk, off during reset
`define SMTP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smtp check failed");

`endif

FILE: rtl/core/smtp_pkg.sv
package smtp_pkg;

	localparam logic [7:0] SAME_MAX      = 8'd63;
	localparam logic [7:0] ONE_STACK_MAX = 8'd127;
	localparam logic [7:0] ONE_STACK_EXT = 8'd247;
	localparam logic [7:0] CHOP_MIN      = 8'd248;
	localparam logic [7:0] SAME_EXT      = 8'd251;
	localparam logic [7:0] APPEND_MIN    = 8'd252;
	localparam logic [7:0] APPEND_MAX    = 8'd254;
	localparam logic [7:0] FRAME_FULL    = 8'd255;
	localparam logic [7:0] TAG_OBJECT    = 8'd7;
	localparam logic [7:0] TAG_UNINIT    = 8'd8;

	typedef enum logic [13:0] {
		PH_IDLE       = 14'b00000000000001,
		PH_COUNT_LO   = 14'b00000000000010,
		PH_FRAME_TYPE = 14'b00000000000100,
		PH_DELTA_HI   = 14'b00000000001000,
		PH_DELTA_LO   = 14'b00000000010000,
		PH_TAG        = 14'b00000000100000,
		PH_OBJ_HI     = 14'b00000001000000,
		PH_OBJ_LO     = 14'b00000010000000,
		PH_UNI_HI     = 14'b00000100000000,
		PH_UNI_LO     = 14'b00001000000000,
		PH_NLOC_HI    = 14'b00010000000000,
		PH_NLOC_LO    = 14'b00100000000000,
		PH_NSTK_HI    = 14'b01000000000000,
		PH_NSTK_LO    = 14'b10000000000000
	} phase_t;

	typedef enum logic [3:0] {
		KIND_COUNT      = 4'd0,
		KIND_FRAME_TYPE = 4'd1,
		KIND_DELTA      = 4'd2,
		KIND_NLOCALS    = 4'd3,
		KIND_NSTACK     = 4'd4,
		KIND_TAG        = 4'd5,
		KIND_POOL_INDEX = 4'd6,
		KIND_NEW_OFFSET = 4'd7,
		KIND_BAD_FRAME  = 4'd8,
		KIND_BAD_TAG    = 4'd9
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  high_byte;
		logic [15:0] frames_left;
		logic [15:0] types_left;
		logic [7:0]  frame_code;
		logic        stack_flag;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic        in_stack_list;
		logic        frame_end;
		logic        table_end;
	} token_t;

endpackage

FILE: rtl/core/smtp_byte_if.sv
interface smtp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       table_start;

	modport source (output valid, output data_byte, output table_start, input ready);
	modport sink (input valid, input data_byte, input table_start, output ready);
endinterface

FILE: rtl/core/smtp_token_if.sv
interface smtp_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_value;
	logic        in_stack_list;
	logic        frame_end;
	logic        table_end;

	modport source (
		output valid, output token_kind, output token_value,
		output in_stack_list, output frame_end, output table_end,
		input ready
	);
	modport sink (
		input valid, input token_kind, input token_value,
		input in_stack_list, input frame_end, input table_end,
		output ready
	);
endinterface

FILE: rtl/core/smtp_decode.sv
module smtp_decode (
	input  smtp_pkg::state_t cur,
	input  logic [7:0]       data_byte,
	input  logic             table_start,
	output smtp_pkg::state_t nxt,
	output smtp_pkg::token_t tok,
	output logic             tok_valid
);
	import smtp_pkg::*;

	logic [15:0] v;
	logic [15:0] frames_dec;
	logic [15:0] types_dec;
	logic        end_type;
	logic        end_frame;

	assign v          = {cur.high_byte, data_byte};
	assign frames_dec = cur.frames_left - 16'd1;
	assign types_dec  = cur.types_left - 16'd1;

	always_comb begin
		nxt       = cur;
		tok       = '{kind: KIND_COUNT, value: 16'd0, in_stack_list: 1'b0,
			frame_end: 1'b0, table_end: 1'b0};
		tok_valid = 1'b0;
		end_type  = 1'b0;
		end_frame = 1'b0;

		if (table_start) begin
			// restart: drop whatever was in flight
			nxt.phase       = PH_COUNT_LO;
			nxt.high_byte   = data_byte;
			nxt.frames_left = 16'd0;
			nxt.types_left  = 16'd0;
			nxt.frame_code  = 8'd0;
			nxt.stack_flag  = 1'b0;
		end else begin
			unique case (cur.phase)
				PH_COUNT_LO: begin
					nxt.frames_left = v;
					tok_valid       = 1'b1;
					tok.kind        = KIND_COUNT;
					tok.value       = v;
					if (v == 16'd0) begin
						nxt.phase     = PH_IDLE;
						tok.table_end = 1'b1;
					end else begin
						nxt.phase = PH_FRAME_TYPE;
					end
				end
				PH_FRAME_TYPE: begin
					nxt.frame_code = data_byte;
					tok_valid      = 1'b1;
					tok.kind       = KIND_FRAME_TYPE;
					tok.value      = {8'd0, data_byte};
					if (data_byte <= SAME_MAX) begin
						end_frame = 1'b1;
					end else if (data_byte <= ONE_STACK_MAX) begin
						nxt.types_left = 16'd1;
						nxt.stack_flag = 1'b1;
						nxt.phase      = PH_TAG;
					end else if (data_byte < ONE_STACK_EXT) begin
						nxt.phase     = PH_IDLE;
						tok.kind      = KIND_BAD_FRAME;
						tok.table_end = 1'b1;
					end else begin
						nxt.phase = PH_DELTA_HI;
					end
				end
				PH_DELTA_HI, PH_OBJ_HI, PH_UNI_HI, PH_NLOC_HI, PH_NSTK_HI: begin
					nxt.high_byte = data_byte;
					nxt.phase     = phase_t'({cur.phase[12:0], 1'b0});
				end
				PH_DELTA_LO: begin
					tok_valid = 1'b1;
					tok.kind  = KIND_DELTA;
					tok.value = v;
					if (cur.frame_code == ONE_STACK_EXT) begin
						nxt.types_left = 16'd1;
						nxt.stack_flag = 1'b1;
						nxt.phase      = PH_TAG;
					end else if (cur.frame_code >= CHOP_MIN && cur.frame_code <= SAME_EXT) begin
						end_frame = 1'b1;
					end else if (cur.frame_code >= APPEND_MIN
						&& cur.frame_code <= APPEND_MAX) begin
						nxt.types_left = {8'd0, cur.frame_code - SAME_EXT};
						nxt.stack_flag = 1'b0;
						nxt.phase      = PH_TAG;
					end else begin
						nxt.phase = PH_NLOC_HI;
					end
				end
				PH_NLOC_LO: begin
					nxt.stack_flag = 1'b0;
					tok_valid      = 1'b1;
					tok.kind       = KIND_NLOCALS;
					tok.value      = v;
					if (v == 16'd0) begin
						nxt.phase = PH_NSTK_HI;
					end else begin
						nxt.types_left = v;
						nxt.phase      = PH_TAG;
					end
				end
				PH_NSTK_LO: begin
					nxt.stack_flag = 1'b1;
					tok_valid      = 1'b1;
					tok.kind       = KIND_NSTACK;
					tok.value      = v;
					if (v == 16'd0) begin
						end_frame = 1'b1;
					end else begin
						nxt.types_left = v;
						nxt.phase      = PH_TAG;
					end
				end
				PH_TAG: begin
					tok_valid         = 1'b1;
					tok.kind          = KIND_TAG;
					tok.value         = {8'd0, data_byte};
					tok.in_stack_list = cur.stack_flag;
					if (data_byte > TAG_UNINIT) begin
						nxt.phase     = PH_IDLE;
						tok.kind      = KIND_BAD_TAG;
						tok.table_end = 1'b1;
					end else if (data_byte == TAG_OBJECT) begin
						nxt.phase = PH_OBJ_HI;
					end else if (data_byte == TAG_UNINIT) begin
						nxt.phase = PH_UNI_HI;
					end else begin
						end_type = 1'b1;
					end
				end
				PH_OBJ_LO: begin
					tok_valid         = 1'b1;
					tok.kind          = KIND_POOL_INDEX;
					tok.value         = v;
					tok.in_stack_list = cur.stack_flag;
					end_type          = 1'b1;
				end
				PH_UNI_LO: begin
					tok_valid         = 1'b1;
					tok.kind          = KIND_NEW_OFFSET;
					tok.value         = v;
					tok.in_stack_list = cur.stack_flag;
					end_type          = 1'b1;
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase

			// end of one verification type
			if (end_type) begin
				nxt.types_left = types_dec;
				if (types_dec != 16'd0) begin
					nxt.phase = PH_TAG;
				end else if (cur.frame_code == FRAME_FULL && !cur.stack_flag) begin
					nxt.phase = PH_NSTK_HI;
				end else begin
					end_frame = 1'b1;
				end
			end

			if (end_frame) begin
				nxt.frames_left = frames_dec;
				tok.frame_end   = 1'b1;
				if (frames_dec == 16'd0) begin
					nxt.phase     = PH_IDLE;
					tok.table_end = 1'b1;
				end else begin
					nxt.phase = PH_FRAME_TYPE;
				end
			end
		end
	end
endmodule

FILE: rtl/core/smtp_out_reg.sv
module smtp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             tok_valid,
	input  smtp_pkg::token_t tok,
	output logic             space,
	smtp_token_if.source     tokens
);
	import smtp_pkg::*;

	logic   valid_q;
	token_t token_q;

	assign space = !valid_q || tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load && tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load && tok_valid) begin
			token_q <= tok;
		end
	end

	assign tokens.valid         = valid_q;
	assign tokens.token_kind    = token_q.kind;
	assign tokens.token_value   = token_q.value;
	assign tokens.in_stack_list = token_q.in_stack_list;
	assign tokens.frame_end     = token_q.frame_end;
	assign tokens.table_end     = token_q.table_end;
endmodule

FILE: rtl/core/stack_map_table_parser.sv
// stack map table parser: one byte request in, at most one token out
// a byte goes from the byte register through the decode into the token register, which offers its token
// throughput: one byte per cycle, set by the combinational decode between the
// byte register and the token register; a stalled token holds the decode back
// reset: asynchronous, clears the byte and token valids and puts the parser idle
module stack_map_table_parser (
	input  logic       clk,
	input  logic       arst_n,
	smtp_byte_if.sink  bytes,
	smtp_token_if.source tokens
);
	import smtp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       table_start_s1;
	state_t     state_q;
	state_t     state_nxt;
	token_t     tok;
	logic       tok_valid;
	logic       space;
	logic       consume;

	assign consume     = valid_s1 && space;
	assign bytes.ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_byte_s1   <= bytes.data_byte;
			table_start_s1 <= bytes.table_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, high_byte: 8'd0, frames_left: 16'd0,
				types_left: 16'd0, frame_code: 8'd0, stack_flag: 1'b0};
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	smtp_decode u_decode (
		.cur         (state_q),
		.data_byte   (data_byte_s1),
		.table_start (table_start_s1),
		.nxt         (state_nxt),
		.tok         (tok),
		.tok_valid   (tok_valid)
	);

	smtp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume),
		.tok_valid (tok_valid),
		.tok       (tok),
		.space     (space),
		.tokens    (tokens)
	);
endmodule

FILE: rtl/core/smtp_checker.sv
`include "stack_map_table_parser_assert.svh"

module smtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  token_kind,
	input logic        in_stack_list,
	input logic        frame_end,
	input logic        table_end
);
	import smtp_pkg::*;

	// a stalled token stays on offer
	`SMTP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)

	// errors always stop the table
	`SMTP_ASSERT_IMPL(a_err_end, out_valid && (token_kind == KIND_BAD_FRAME || token_kind == KIND_BAD_TAG), table_end)

	// list flag only on type tokens
	`SMTP_ASSERT_IMPL(a_list_flag, out_valid && (token_kind == KIND_COUNT || token_kind == KIND_FRAME_TYPE || token_kind == KIND_DELTA || token_kind == KIND_NLOCALS || token_kind == KIND_NSTACK || token_kind == KIND_BAD_FRAME), !in_stack_list)

	// table completion inside a frame must close that frame
	`SMTP_ASSERT_IMPL(a_end_frame, out_valid && table_end && token_kind != KIND_COUNT && token_kind != KIND_BAD_FRAME && token_kind != KIND_BAD_TAG, frame_end)
endmodule

bind stack_map_table_parser smtp_checker u_smtp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (tokens.valid),
	.out_ready     (tokens.ready),
	.token_kind    (tokens.token_kind),
	.in_stack_list (tokens.in_stack_list),
	.frame_end     (tokens.frame_end),
	.table_end     (tokens.table_end)
);
